/* rtl/phase_current_sense_protect_defines.svh */
// Assertion macros for the phase current sense protect block.
// Included by the modules that check their own logic; needs clock and reset in scope.
`ifndef PHASE_CURRENT_SENSE_PROTECT_DEFINES_SVH
`define PHASE_CURRENT_SENSE_PROTECT_DEFINES_SVH

// same-cycle implication
`define PCSP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PCSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pcsp_pkg.sv */
// Shared types and constants for the phase current sense protect block.
// No dependencies; imported by the lane, merge and top modules.
`timescale 1ns / 1ps

package pcsp_pkg;

   localparam int SAMPLE_W = 12;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 20;
   localparam int CUR_W    = 21;
   localparam int CNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // diff is 13 bits signed, gain 17 bits signed once zero-extended
   localparam int PROD_W = SAMPLE_W + 1 + GAIN_W + 1;
   localparam int RND_W  = PROD_W - 8;

   localparam logic [SAMPLE_W-1:0] OFFSET_LO = SAMPLE_W'(1948);
   localparam logic [SAMPLE_W-1:0] OFFSET_HI = SAMPLE_W'(2148);

   localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(128);
   localparam logic [RND_W-1:0]  MAG_POS_MAX = RND_W'(1048575);
   localparam logic [RND_W-1:0]  MAG_NEG_MAX = RND_W'(1048576);

   localparam logic [SAMPLE_W-1:0]  OFFSET_RST = SAMPLE_W'(2048);
   localparam logic [GAIN_W-1:0]    GAIN_RST   = GAIN_W'(256);
   localparam logic [LIMIT_W-1:0]   LIMIT_RST  = LIMIT_W'(20000);

   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_A = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_B = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_C = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT    = CSR_IDX_W'(4);

   typedef struct packed {
      logic s1_load;       // lanes capture a new item
      logic s2_load;       // merge stage takes the lane results
      logic offset_fault;  // an offset is out of its window
   } pcsp_ctrl_type;

endpackage

/* rtl/phase_current_sense_protect.sv */
// Top level of the phase current sense protect block: configuration
// registers, handshake control, three phase lanes and the merge stage.
// Depends on pcsp_pkg, pcsp_lane and pcsp_merge.
`timescale 1ns / 1ps

// Takes one item of three 12-bit phase samples per cycle and returns one
// result per item: the three held phase currents in mA and the offset and
// overcurrent flags. Each phase has its own lane. A lane runs a 13x17
// multiply into a product register, then rounds and saturates the product.
// The merge stage holds the currents, compares all three against the trip
// limit and runs the confirm counter. An accepted item goes into the lane
// product register and then into the result register, which holds it until
// the result side takes it. One item is taken every cycle as long as the
// result side keeps up. The result register and the lane register absorb a
// stall. Write the configuration only while no item is in flight.
module phase_current_sense_protect
   import pcsp_pkg::*;
#(
   parameter int CONFIRM_CYCLES = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_W-1:0]        req_sample_a,
   input  logic [SAMPLE_W-1:0]        req_sample_b,
   input  logic [SAMPLE_W-1:0]        req_sample_c,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [CUR_W-1:0]    rsp_current_a,
   output logic signed [CUR_W-1:0]    rsp_current_b,
   output logic signed [CUR_W-1:0]    rsp_current_c,
   output logic                       rsp_offset_fault,
   output logic                       rsp_overcurrent_fault,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   logic [SAMPLE_W-1:0]      offset_ff [3];
   logic [GAIN_W-1:0]        gain_ff;
   logic [LIMIT_W-1:0]       limit_ff;
   logic                     s1_valid_ff;
   logic                     out_ready;
   logic                     accept;
   logic                     ofault;
   pcsp_ctrl_type            ctrl;
   logic [SAMPLE_W-1:0]      sample [3];
   logic signed [CUR_W-1:0]  lane_cur [3];
   logic [CUR_W-1:0]         lane_mag [3];
   logic signed [CUR_W-1:0]  rsp_current [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            offset_ff[i] <= OFFSET_RST;
         end
         gain_ff  <= GAIN_RST;
         limit_ff <= LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_OFFSET_A: offset_ff[0] <= csr_wdata[SAMPLE_W-1:0];
            REG_OFFSET_B: offset_ff[1] <= csr_wdata[SAMPLE_W-1:0];
            REG_OFFSET_C: offset_ff[2] <= csr_wdata[SAMPLE_W-1:0];
            REG_GAIN:     gain_ff      <= csr_wdata[GAIN_W-1:0];
            REG_LIMIT:    limit_ff     <= csr_wdata[LIMIT_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_comb begin
      ofault = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (offset_ff[i] < OFFSET_LO || offset_ff[i] > OFFSET_HI) begin
            ofault = 1'b1;
         end
      end
   end

   // lane stage advances when the result register is free or draining
   assign out_ready = !rsp_valid || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   assign ctrl.s1_load      = accept;
   assign ctrl.s2_load      = s1_valid_ff && out_ready;
   assign ctrl.offset_fault = ofault;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (ctrl.s2_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   assign sample[0] = req_sample_a;
   assign sample[1] = req_sample_b;
   assign sample[2] = req_sample_c;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      pcsp_lane u_lane (
         .clock     (clock),
         .load      (ctrl.s1_load),
         .sample    (sample[g]),
         .offset    (offset_ff[g]),
         .gain      (gain_ff),
         .current   (lane_cur[g]),
         .magnitude (lane_mag[g])
      );
   end

   pcsp_merge #(
      .CONFIRM_CYCLES (CONFIRM_CYCLES)
   ) u_merge (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl                  (ctrl),
      .rsp_stall             (rsp_stall),
      .trip_limit            (limit_ff),
      .lane_cur              (lane_cur),
      .lane_mag              (lane_mag),
      .rsp_valid             (rsp_valid),
      .rsp_current           (rsp_current),
      .rsp_offset_fault      (rsp_offset_fault),
      .rsp_overcurrent_fault (rsp_overcurrent_fault)
   );

   assign rsp_current_a = rsp_current[0];
   assign rsp_current_b = rsp_current[1];
   assign rsp_current_c = rsp_current[2];

endmodule

/* rtl/pcsp_lane.sv */
// One phase lane: offset subtract and gain multiply, registered, then
// rounding and saturation of the product. Depends on pcsp_pkg.
`timescale 1ns / 1ps

module pcsp_lane
   import pcsp_pkg::*;
(
   input  logic                       clock,
   input  logic                       load,
   input  logic [SAMPLE_W-1:0]        sample,
   input  logic [SAMPLE_W-1:0]        offset,
   input  logic [GAIN_W-1:0]          gain,
   output logic signed [CUR_W-1:0]    current,
   output logic [CUR_W-1:0]           magnitude
);

   logic signed [SAMPLE_W:0]   diff;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       neg;
   logic [PROD_W-1:0]          abs_prod;
   logic [PROD_W-1:0]          rnd_sum;
   logic [RND_W-1:0]           rnd;
   logic [RND_W-1:0]           lim;
   logic [RND_W-1:0]           mag_sat;
   logic [CUR_W-1:0]           mag;

   // current is -(sample - offset) * gain / 256
   assign diff    = $signed({1'b0, offset}) - $signed({1'b0, sample});
   assign gain_s  = $signed({1'b0, gain});
   assign prod_in = PROD_W'(diff * gain_s);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // round half away from zero on the magnitude, then clamp
   assign neg      = prod_ff[PROD_W-1];
   assign abs_prod = neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign rnd_sum  = abs_prod + ROUND_HALF;
   assign rnd      = rnd_sum[PROD_W-1:8];
   assign lim      = neg ? MAG_NEG_MAX : MAG_POS_MAX;
   assign mag_sat  = (rnd > lim) ? lim : rnd;
   assign mag      = mag_sat[CUR_W-1:0];

   assign magnitude = mag;
   assign current   = neg ? $signed(-mag) : $signed(mag);

endmodule

/* rtl/pcsp_merge.sv */
// Merge stage: held currents, trip compare across the three lanes, confirm
// counter and the result register. Depends on pcsp_pkg and the defines header.
`timescale 1ns / 1ps
`include "phase_current_sense_protect_defines.svh"

module pcsp_merge
   import pcsp_pkg::*;
#(
   parameter int CONFIRM_CYCLES = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pcsp_ctrl_type              ctrl,
   input  logic                       rsp_stall,
   input  logic [LIMIT_W-1:0]         trip_limit,
   input  logic signed [CUR_W-1:0]    lane_cur [3],
   input  logic [CUR_W-1:0]           lane_mag [3],
   output logic                       rsp_valid,
   output logic signed [CUR_W-1:0]    rsp_current [3],
   output logic                       rsp_offset_fault,
   output logic                       rsp_overcurrent_fault
);

   localparam logic [CNT_W-1:0] CONFIRM_MAX = CNT_W'(CONFIRM_CYCLES);

   logic signed [CUR_W-1:0]  held_ff [3];
   logic signed [CUR_W-1:0]  held_in [3];
   logic [CUR_W-1:0]         held_mag_ff [3];
   logic [CUR_W-1:0]         held_mag_in [3];
   logic [2:0]               over_lane;
   logic                     over;
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         cnt_in;
   logic                     oc_in;
   logic                     valid_ff;
   logic signed [CUR_W-1:0]  cur_ff [3];
   logic                     ofault_ff;
   logic                     oc_ff;

   // keep the previous currents while an offset is bad
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         held_in[i]     = ctrl.offset_fault ? held_ff[i] : lane_cur[i];
         held_mag_in[i] = ctrl.offset_fault ? held_mag_ff[i] : lane_mag[i];
         over_lane[i]   = held_mag_in[i] > {1'b0, trip_limit};
      end
   end

   assign over = |over_lane;

   always_comb begin
      cnt_in = cnt_ff;
      if (over) begin
         if (cnt_ff < CONFIRM_MAX) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else begin
         cnt_in = '0;
      end
      oc_in = over && (cnt_in >= CONFIRM_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            held_ff[i]     <= '0;
            held_mag_ff[i] <= '0;
         end
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (ctrl.s2_load) begin
            held_ff     <= held_in;
            held_mag_ff <= held_mag_in;
            cnt_ff      <= cnt_in;
            valid_ff    <= 1'b1;
         end else if (valid_ff && !rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         cur_ff    <= held_in;
         ofault_ff <= ctrl.offset_fault;
         oc_ff     <= oc_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_current           = cur_ff;
   assign rsp_offset_fault      = ofault_ff;
   assign rsp_overcurrent_fault = oc_ff;

   `PCSP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_ff <= CONFIRM_MAX, "confirm count above limit")
   `PCSP_ASSERT_IMPL(a_oc_needs_cnt, valid_ff && oc_ff, cnt_ff == CONFIRM_MAX,
      "overcurrent flagged without a saturated count")
   `PCSP_ASSERT_NEXT(a_cnt_clear, ctrl.s2_load && !over, cnt_ff == '0,
      "confirm count not cleared")
   `PCSP_ASSERT_NEXT(a_hold_on_fault, ctrl.s2_load && ctrl.offset_fault,
      held_ff[0] == $past(held_ff[0]) && held_ff[1] == $past(held_ff[1]) &&
      held_ff[2] == $past(held_ff[2]), "held currents changed under offset fault")

endmodule

/* verif/pcsp_checker.sv */
// Checker for the phase current sense protect block: watches the request, result and
// register ports, predicts each result and compares it field by field.
// Depends on pcsp_pkg.
`timescale 1ns / 1ps

module pcsp_checker
   import pcsp_pkg::*;
#(
   parameter int CONFIRM_CYCLES = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [SAMPLE_W-1:0]     req_sample_a,
   input  logic [SAMPLE_W-1:0]     req_sample_b,
   input  logic [SAMPLE_W-1:0]     req_sample_c,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [CUR_W-1:0] rsp_current_a,
   input  logic signed [CUR_W-1:0] rsp_current_b,
   input  logic signed [CUR_W-1:0] rsp_current_c,
   input  logic                    rsp_offset_fault,
   input  logic                    rsp_overcurrent_fault,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      pending,
   output int                      fail_count
);

   typedef struct packed {
      logic signed [CUR_W-1:0] current_a;
      logic signed [CUR_W-1:0] current_b;
      logic signed [CUR_W-1:0] current_c;
      logic                    offset_fault;
      logic                    overcurrent_fault;
   } phase_reading_type;

   phase_reading_type       readings_due[$];
   logic [SAMPLE_W-1:0]     zero_a, zero_b, zero_c;
   logic [GAIN_W-1:0]       gain;
   logic [LIMIT_W-1:0]      trip_limit;
   logic signed [CUR_W-1:0] held [3];
   logic [CNT_W-1:0]        confirm;

   // -(sample - zero) * gain / 256, rounded half away from zero, clamped to 21 bits
   function automatic logic signed [CUR_W-1:0] phase_milliamps(
      input logic [SAMPLE_W-1:0] sample,
      input logic [SAMPLE_W-1:0] zero,
      input logic [GAIN_W-1:0]   g);
      longint prod;
      longint mag;
      prod = (longint'(zero) - longint'(sample)) * longint'(g);
      mag = (prod < 0) ? -prod : prod;
      mag = (mag + 128) >>> 8;
      if (mag > 1048576)
         mag = 1048576;
      if (prod < 0)
         mag = -mag;
      else if (mag > 1048575)
         mag = 1048575;
      return CUR_W'(mag);
   endfunction

   function automatic bit zero_in_window(input logic [SAMPLE_W-1:0] z);
      return z >= OFFSET_LO && z <= OFFSET_HI;
   endfunction

   function automatic phase_reading_type protect_step(
      input logic [SAMPLE_W-1:0] sa,
      input logic [SAMPLE_W-1:0] sb,
      input logic [SAMPLE_W-1:0] sc);
      phase_reading_type r;
      bit                tripped;
      longint            mag;
      r.offset_fault = !(zero_in_window(zero_a) && zero_in_window(zero_b)
                         && zero_in_window(zero_c));
      // hold the previous currents while an offset is out of its window
      if (!r.offset_fault) begin
         held[0] = phase_milliamps(sa, zero_a, gain);
         held[1] = phase_milliamps(sb, zero_b, gain);
         held[2] = phase_milliamps(sc, zero_c, gain);
      end
      tripped = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag = longint'(held[i]);
         if (mag < 0)
            mag = -mag;
         if (mag > longint'(trip_limit))
            tripped = 1'b1;
      end
      if (tripped) begin
         if (confirm < CNT_W'(CONFIRM_CYCLES))
            confirm = confirm + 1'b1;
      end else begin
         confirm = '0;
      end
      r.overcurrent_fault = tripped && (confirm >= CNT_W'(CONFIRM_CYCLES));
      r.current_a = held[0];
      r.current_b = held[1];
      r.current_c = held[2];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [CUR_W-1:0] want,
                              input logic [CUR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      phase_reading_type want;
      if (reset) begin
         zero_a = OFFSET_RST;
         zero_b = OFFSET_RST;
         zero_c = OFFSET_RST;
         gain = GAIN_RST;
         trip_limit = LIMIT_RST;
         held = '{default: '0};
         confirm = '0;
         readings_due.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_OFFSET_A: zero_a = csr_wdata[SAMPLE_W-1:0];
               REG_OFFSET_B: zero_b = csr_wdata[SAMPLE_W-1:0];
               REG_OFFSET_C: zero_c = csr_wdata[SAMPLE_W-1:0];
               REG_GAIN:     gain = csr_wdata[GAIN_W-1:0];
               REG_LIMIT:    trip_limit = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            readings_due.push_back(protect_step(req_sample_a, req_sample_b, req_sample_c));
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               $error("result accepted with no item outstanding");
               fail_count++;
            end else begin
               want = readings_due.pop_front();
               check_field("current_a", want.current_a, rsp_current_a);
               check_field("current_b", want.current_b, rsp_current_b);
               check_field("current_c", want.current_c, rsp_current_c);
               check_field("offset_fault", CUR_W'(want.offset_fault),
                           CUR_W'(rsp_offset_fault));
               check_field("overcurrent_fault", CUR_W'(want.overcurrent_fault),
                           CUR_W'(rsp_overcurrent_fault));
            end
         end
      end
      pending <= readings_due.size();
   end

endmodule

/* verif/tb_phase_current_sense_protect.sv */
// Testbench top for the phase current sense protect block: clock, reset, register
// programming and sample stimulus with random idling; the verdict comes from pcsp_checker.
// Depends on pcsp_pkg, phase_current_sense_protect and pcsp_checker.
`timescale 1ns / 1ps

module tb_phase_current_sense_protect;
   import pcsp_pkg::*;

   localparam int CONFIRM_CYCLES = 5;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS = 50;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = CSR_IDX_W'(7);

   typedef enum int {
      SETUP_NOMINAL,
      SETUP_WINDOW_EDGES,
      SETUP_ZERO_GAIN,
      SETUP_ZERO_TRIP,
      SETUP_NEVER_TRIP,
      SETUP_OFFSET_FAULT,
      SETUP_RANDOM
   } setup_kind_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [SAMPLE_W-1:0]     req_sample_a = '0;
   logic [SAMPLE_W-1:0]     req_sample_b = '0;
   logic [SAMPLE_W-1:0]     req_sample_c = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [CUR_W-1:0] rsp_current_a;
   logic signed [CUR_W-1:0] rsp_current_b;
   logic signed [CUR_W-1:0] rsp_current_c;
   logic                    rsp_offset_fault;
   logic                    rsp_overcurrent_fault;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   int                      pending;
   int                      fail_count;

   int             idle_odds = 0;
   int             zero_cnt [3];
   int             gain_cfg;
   int             trip_cfg;
   int             swing;
   setup_kind_type phase_plan [RANDOM_PHASES] = '{SETUP_RANDOM, SETUP_WINDOW_EDGES,
      SETUP_ZERO_GAIN, SETUP_ZERO_TRIP, SETUP_RANDOM, SETUP_NEVER_TRIP,
      SETUP_OFFSET_FAULT, SETUP_NOMINAL, SETUP_RANDOM};

   phase_current_sense_protect #(.CONFIRM_CYCLES(CONFIRM_CYCLES)) DUT (.*);

   pcsp_checker #(.CONFIRM_CYCLES(CONFIRM_CYCLES)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb_phase_current_sense_protect: errors");
      $finish;
   end

   // result side: stall in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input int a, input int b, input int c);
      if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_a <= SAMPLE_W'(a);
      req_sample_b <= SAMPLE_W'(b);
      req_sample_c <= SAMPLE_W'(c);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the sender until every outstanding result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic close_writes();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // fill the bits above the register width with noise
   function automatic logic [CSR_DATA_W-1:0] pad_junk(input int value, input int width);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      for (int i = 0; i < width; i++)
         word[i] = value[i];
      return word;
   endfunction

   function automatic int in_window();
      return int'($urandom_range(OFFSET_LO, OFFSET_HI));
   endfunction

   task automatic program_phase(input setup_kind_type kind);
      int k;
      drain();
      for (int i = 0; i < 3; i++)
         zero_cnt[i] = in_window();
      gain_cfg = int'($urandom_range(256, 65535));
      trip_cfg = int'($urandom_range(0, (4095 * gain_cfg) / 256));
      case (kind)
         SETUP_NOMINAL: begin
            zero_cnt = '{2048, 2048, 2048};
            gain_cfg = 256;
            trip_cfg = 20000;
         end
         SETUP_WINDOW_EDGES: begin
            zero_cnt[0] = OFFSET_LO;
            zero_cnt[1] = OFFSET_HI;
            gain_cfg = 65535;
            trip_cfg = int'($urandom_range(20000, 150000));
         end
         SETUP_ZERO_GAIN: begin
            gain_cfg = 0;
            trip_cfg = 0;
         end
         SETUP_ZERO_TRIP: begin
            gain_cfg = int'($urandom_range(1, 65535));
            trip_cfg = 0;
         end
         SETUP_NEVER_TRIP: begin
            gain_cfg = 65535;
            trip_cfg = 1048575;
         end
         SETUP_OFFSET_FAULT: begin
            k = int'($urandom_range(0, 2));
            zero_cnt[k] = $urandom_range(0, 1) ? int'($urandom_range(0, OFFSET_LO - 1))
                                               : int'($urandom_range(OFFSET_HI + 1, 4095));
            trip_cfg = int'($urandom_range(0, 50000));
         end
         default: ;
      endcase
      set_reg(REG_OFFSET_A, pad_junk(zero_cnt[0], SAMPLE_W));
      set_reg(REG_OFFSET_B, pad_junk(zero_cnt[1], SAMPLE_W));
      set_reg(REG_OFFSET_C, pad_junk(zero_cnt[2], SAMPLE_W));
      set_reg(REG_GAIN, pad_junk(gain_cfg, GAIN_W));
      set_reg(REG_LIMIT, CSR_DATA_W'(trip_cfg));
      close_writes();
      // sample distance from zero at which a phase crosses the trip limit
      swing = (gain_cfg == 0) ? 4096 : (trip_cfg * 256) / gain_cfg;
      if (swing > 4096)
         swing = 4096;
   endtask

   function automatic int pick_sample(input int zero, input bit hot);
      int s;
      int lo;
      int hi;
      lo = zero - swing - 1;
      hi = zero + swing + 1;
      case ($urandom_range(0, 9))
         0: s = int'($urandom_range(0, 4095));
         1: s = zero + ($urandom_range(0, 1) ? swing : -swing) + int'($urandom_range(0, 2)) - 1;
         default: begin
            if (!hot)
               s = zero + int'($urandom_range(0, swing)) - swing / 2;
            else if (lo < 0 && hi > 4095)
               s = int'($urandom_range(0, 4095));
            else if (hi > 4095 || (lo >= 0 && $urandom_range(0, 1)))
               s = int'($urandom_range(0, lo));
            else
               s = int'($urandom_range(hi, 4095));
         end
      endcase
      if (s < 0)
         s = 0;
      if (s > 4095)
         s = 4095;
      return s;
   endfunction

   initial begin
      int sent;
      int run_len;
      int hot_phase;
      bit hot;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_odds = 20;
      send_item(0, 4095, 2048);
      send_item(4095, 0, 'hAAA);
      send_item('h555, 'hFFF, 0);
      drain();
      set_reg(REG_GAIN, CSR_DATA_W'(128));
      close_writes();
      // most of these products are half counts and sit exactly on the rounding tie
      send_item(2047, 2049, 2045);
      send_item(2048, 2046, 2051);
      drain();
      set_reg(REG_OFFSET_A, pad_junk(OFFSET_LO, SAMPLE_W));
      set_reg(REG_OFFSET_B, pad_junk(OFFSET_HI, SAMPLE_W));
      set_reg(REG_GAIN, CSR_DATA_W'(65535));
      set_reg(REG_LIMIT, CSR_DATA_W'(0));
      close_writes();
      repeat (3) begin
         send_item(0, 4095, 0);
         send_item(4095, 0, 4095);
      end
      send_item(OFFSET_LO, OFFSET_HI, 2048);
      send_item(OFFSET_LO + 1, OFFSET_HI, 2048);
      // offset fault with a held current above the limit: both flags together
      drain();
      set_reg(REG_OFFSET_A, CSR_DATA_W'(OFFSET_LO - 1));
      set_reg(REG_SPARE_LO, CSR_DATA_W'($urandom));
      set_reg(REG_SPARE_HI, CSR_DATA_W'($urandom));
      close_writes();
      repeat (6)
         send_item($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
      drain();
      set_reg(REG_OFFSET_A, CSR_DATA_W'(OFFSET_HI + 1));
      close_writes();
      send_item(0, 4095, 0);
      drain();
      set_reg(REG_OFFSET_A, CSR_DATA_W'(0));
      close_writes();
      send_item(4095, 0, 4095);
      drain();
      set_reg(REG_OFFSET_A, CSR_DATA_W'(4095));
      close_writes();
      send_item(2048, 2048, 2048);
      drain();
      set_reg(REG_OFFSET_A, CSR_DATA_W'(OFFSET_HI));
      set_reg(REG_LIMIT, CSR_DATA_W'(1048575));
      close_writes();
      send_item(0, 0, 0);
      send_item(4095, 4095, 4095);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_phase(phase_plan[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_len = int'($urandom_range(1, 8));
            hot = $urandom_range(0, 1);
            hot_phase = int'($urandom_range(0, 2));
            if (p == RANDOM_PHASES - 1)
               idle_odds = 0;
            else
               case ($urandom_range(0, 2))
                  0: idle_odds = 0;
                  1: idle_odds = 15;
                  default: idle_odds = 40;
               endcase
            // runs of over-limit items exercise the confirm counter and its clearing
            for (int r = 0; r < run_len && sent < PHASE_ITEMS; r++) begin
               send_item(pick_sample(zero_cnt[0], hot && (hot_phase == 0 || $urandom_range(0, 1))),
                         pick_sample(zero_cnt[1], hot && (hot_phase == 1 || $urandom_range(0, 1))),
                         pick_sample(zero_cnt[2], hot && (hot_phase == 2 || $urandom_range(0, 1))));
               sent++;
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb_phase_current_sense_protect: clean");
      else
         $display("tb_phase_current_sense_protect: errors");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/pcsp_pkg.sv
rtl/pcsp_lane.sv
rtl/pcsp_merge.sv
rtl/phase_current_sense_protect.sv
verif/pcsp_checker.sv
verif/tb_phase_current_sense_protect.sv
